// ----- hdl/frame_header_resync_scanner_macros.svh -----
// Assertion macros used by the checker file.
`ifndef FRAME_HEADER_RESYNC_SCANNER_MACROS_SVH
`define FRAME_HEADER_RESYNC_SCANNER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define FRH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FRH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/frh_pkg.sv -----
// Package: types, constants and the magic lookup for the header scanner.
package frh_pkg;

	localparam int MagicCount = 3;

	localparam logic [1:0] CFG_FILE_LENGTH = 2'd0;
	localparam logic [1:0] CFG_MAX_FRAME   = 2'd1;
	localparam logic [1:0] CFG_MIN_FRAME   = 2'd2;

	localparam logic [31:0] FILE_LENGTH_RST = 32'd0;
	localparam logic [23:0] MAX_FRAME_RST   = 24'd2000000;
	localparam logic [23:0] MIN_FRAME_RST   = 24'd140;
	localparam logic [24:0] SKIP_RST        = 25'd7;

	localparam logic [31:0] MAGIC [MagicCount] = '{
		32'h24e92764,
		32'hfa1af9bf,
		32'haae83f5f
	};

	typedef struct packed {
		logic [31:0] file_length;
		logic [23:0] max_frame_size;
		logic [23:0] min_frame_size;
	} cfg_t;

	typedef struct packed {
		logic [31:0] payload_offset;
		logic [23:0] payload_size;
		logic [1:0]  magic_index;
	} res_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] idx;
	} magic_t;

	// First matching pattern wins, as the patterns are distinct anyway.
	function automatic magic_t magic_lookup(input logic [31:0] word);
		magic_t m;
		m.hit = 1'b0;
		m.idx = 2'd0;
		for (int k = MagicCount - 1; k >= 0; k--) begin
			if (word == MAGIC[k]) begin
				m.hit = 1'b1;
				m.idx = 2'(k);
			end
		end
		return m;
	endfunction

endpackage

// ----- hdl/frh_cfg.sv -----
// Configuration register bank for the header scanner.
module frh_cfg import frh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.file_length    <= FILE_LENGTH_RST;
			cfg_q.max_frame_size <= MAX_FRAME_RST;
			cfg_q.min_frame_size <= MIN_FRAME_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FILE_LENGTH: cfg_q.file_length    <= cfg_data;
				CFG_MAX_FRAME:   cfg_q.max_frame_size <= cfg_data[23:0];
				CFG_MIN_FRAME:   cfg_q.min_frame_size <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/frh_scan.sv -----
// Scan state (window, position, skip count) and the header test for one byte.
module frh_scan import frh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_s1,
	input  cfg_t       cfg,
	output logic       hit,
	output res_t       res
);

	logic [63:0] win_q;
	logic [31:0] pos_q;
	logic [24:0] skip_q;

	logic [63:0] win_nxt;
	logic        active;
	logic        testing;
	logic [31:0] size32;
	magic_t      mag;
	logic [32:0] end_pos;
	logic [33:0] lim_min;
	logic [33:0] lim_sz;
	logic        accept;

	assign active  = step && (pos_q < cfg.file_length);
	assign win_nxt = {win_q[55:0], data_s1};
	assign testing = (skip_q == '0);

	// size field is little-endian behind the four magic bytes
	assign size32 = {win_nxt[7:0], win_nxt[15:8], win_nxt[23:16], win_nxt[31:24]};
	assign mag    = magic_lookup(win_nxt[63:32]);

	// header start plus eight is the current position plus one
	assign end_pos = {1'b0, pos_q} + 33'd1;
	assign lim_min = {1'b0, end_pos} + {10'd0, cfg.min_frame_size};
	assign lim_sz  = {1'b0, end_pos} + {10'd0, size32[23:0]};

	assign accept = testing && mag.hit
		&& (size32 != '0) && (size32[31:24] == '0)
		&& (size32[23:0] <= cfg.max_frame_size)
		&& (size32[23:0] >= cfg.min_frame_size)
		&& (lim_min <= {2'b00, cfg.file_length})
		&& (lim_sz <= {2'b00, cfg.file_length});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			pos_q  <= '0;
			skip_q <= SKIP_RST;
		end else if (active) begin
			win_q <= win_nxt;
			pos_q <= pos_q + 32'd1;
			if (!testing)
				skip_q <= skip_q - 25'd1;
			else if (accept)
				skip_q <= {1'b0, size32[23:0]} + 25'd7;
		end
	end

	assign hit                = active && accept;
	assign res.payload_offset = end_pos[31:0];
	assign res.payload_size   = size32[23:0];
	assign res.magic_index    = mag.idx;

endmodule

// ----- hdl/frame_header_resync_scanner.sv -----
// Record-file header scanner: takes one file byte per cycle while the result
// side is not stalled and reports each accepted frame header (payload offset,
// size, magic); the rate is set by the window/position/skip update in
// frh_scan. A result is presented once its last header byte has passed the
// input register, then result register. Bytes at or past file_length are taken
// and dropped. Configuration is written through cfg_wr_en/cfg_index/cfg_data
// while no request is in flight; there is no read-back.
module frame_header_resync_scanner import frh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] payload_offset,
	output logic [23:0] payload_size,
	output logic [1:0]  magic_index
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       out_free;
	logic       step;
	logic       hit;
	res_t       res;
	logic       out_valid_q;
	res_t       res_q;

	frh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			data_s1 <= data_byte;
	end

	frh_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.data_s1 (data_s1),
		.cfg     (cfg),
		.hit     (hit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= hit;
	end

	always_ff @(posedge clk) begin
		if (out_free && hit)
			res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign payload_offset = res_q.payload_offset;
	assign payload_size   = res_q.payload_size;
	assign magic_index    = res_q.magic_index;

endmodule

// ----- hdl/frh_chk.sv -----
// Port-level checker for the header scanner, bound to the top level.
`include "frame_header_resync_scanner_macros.svh"

module frh_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] payload_offset,
	input logic [23:0] payload_size,
	input logic [1:0]  magic_index
);

	`FRH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload_offset) && $stable(payload_size) && $stable(magic_index), "result request dropped or changed while stalled")

	`FRH_ASSERT_IMP(a_res_range, out_valid, (magic_index != 2'd3) && (payload_size != 24'd0), "result magic index or size out of range")

	`FRH_ASSERT_IMP(a_off_min, out_valid, payload_offset >= 32'd8, "payload offset below first header end")

	// successive frames sit at least a header apart
	`FRH_ASSERT_IMP(a_no_repeat, (out_valid && out_ready) ##1 out_valid, payload_offset != $past(payload_offset), "same frame reported twice")

endmodule

bind frame_header_resync_scanner frh_chk u_frh_chk (.*);

// ----- verif/frh_frame_monitor.sv -----
`timescale 1ns / 1ps
// Frame monitor: tracks the scanner's state, predicts reported frames and compares them.
module frh_frame_monitor import frh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] payload_offset,
	input  logic [23:0] payload_size,
	input  logic [1:0]  magic_index,
	output int          mismatches,
	output int          frames_due_cnt
);

	cfg_t        regs;
	logic [63:0] window;
	logic [31:0] file_pos;
	logic [24:0] skip_left;
	res_t        frames_due [$];
	res_t        got;
	res_t        want;

	function automatic void report(input string what, input res_t exp_f, input res_t act_f);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected off %0d size %0d magic %0d, got off %0d size %0d magic %0d",
				$realtime, what, exp_f.payload_offset, exp_f.payload_size, exp_f.magic_index,
				act_f.payload_offset, act_f.payload_size, act_f.magic_index);
	endfunction

	// One accepted request: unless past file_length, shift the byte in and, once no skip is left, test the header window.
	function automatic void scan_byte(input logic [7:0] b);
		logic [31:0] word;
		logic [31:0] size;
		logic [63:0] pay_start;
		int          hit;
		if (file_pos >= regs.file_length)
			return;
		window = {window[55:0], b};
		if (skip_left != 0) begin
			skip_left = skip_left - 1'b1;
			file_pos = file_pos + 1'b1;
			return;
		end
		word = window[63:32];
		size = {window[7:0], window[15:8], window[23:16], window[31:24]};
		hit = -1;
		for (int k = 0; k < MagicCount; k++)
			if (hit < 0 && word == MAGIC[k])
				hit = k;
		// header began seven bytes back, so the payload starts at the next byte
		pay_start = 64'(file_pos) + 64'd1;
		if (hit >= 0 && size != 0 && size <= regs.max_frame_size
				&& size >= regs.min_frame_size
				&& pay_start + regs.min_frame_size <= regs.file_length
				&& pay_start + size <= regs.file_length) begin
			frames_due.push_back(res_t'{pay_start[31:0], size[23:0], 2'(hit)});
			skip_left = 25'(size + 32'd7);
		end
		file_pos = file_pos + 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.file_length = FILE_LENGTH_RST;
			regs.max_frame_size = MAX_FRAME_RST;
			regs.min_frame_size = MIN_FRAME_RST;
			window = '0;
			file_pos = '0;
			skip_left = SKIP_RST;
			frames_due.delete();
			mismatches = 0;
			frames_due_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				got.payload_offset = payload_offset;
				got.payload_size = payload_size;
				got.magic_index = magic_index;
				if (frames_due.size() == 0) begin
					report("frame with none expected", '0, got);
				end else begin
					want = frames_due.pop_front();
					if (got.payload_offset !== want.payload_offset
							|| got.payload_size !== want.payload_size
							|| got.magic_index !== want.magic_index)
						report("frame", want, got);
				end
			end
			if (in_valid && in_ready)
				scan_byte(data_byte);
			// writes only happen while idle; they take effect from the next byte
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FILE_LENGTH: regs.file_length = cfg_data;
					CFG_MAX_FRAME:   regs.max_frame_size = cfg_data[23:0];
					CFG_MIN_FRAME:   regs.min_frame_size = cfg_data[23:0];
					default: ;
				endcase
			end
			frames_due_cnt = frames_due.size();
		end
	end

endmodule

// ----- verif/tb_frame_header_resync_scanner.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, file stimulus, output back-pressure and verdict.
module tb_frame_header_resync_scanner;
	import frh_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;	// unmapped register index
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 650;

	typedef enum int {RX_FREE, RX_EVERY4, RX_COIN, RX_MOSTLY} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] payload_offset;
	logic [23:0] payload_size;
	logic [1:0]  magic_index;
	int          mismatches;
	int          frames_due_cnt;

	logic        hold_req;
	logic [7:0]  file_bytes [$];
	logic [31:0] file_pos;
	logic [31:0] file_len;
	int          burst_left;
	int          n_items;
	int          quiet_cycles = 0;
	int          phase;
	int          chunk_target;
	logic [23:0] lo_size;
	logic [23:0] hi_size;

	frame_header_resync_scanner u_top (.*);

	frh_frame_monitor u_monitor (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("frame_header_resync_scanner: mismatch");
			$finish;
		end
	end

	// Result side back-pressure, plus one long hold when asked.
	initial begin
		rx_mode_t mode;
		int       tick;
		logic     hold_now;
		out_ready = 1'b0;
		mode = RX_FREE;
		tick = 0;
		forever begin
			@(posedge clk);
			hold_now = hold_req;
			@(negedge clk);
			if (hold_now) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (tick % 48 == 0)
				mode = rx_mode_t'($urandom_range(0, 3));
			tick++;
			case (mode)
				RX_FREE:   out_ready <= 1'b1;
				RX_EVERY4: out_ready <= (tick % 4 != 0);
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				default:   out_ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		n_items++;
		if (file_pos < file_len)
			file_pos++;
		@(negedge clk);
	endtask

	task automatic stream_file();
		while (file_bytes.size() != 0)
			push_byte(file_bytes.pop_front());
		in_valid <= 1'b0;
	endtask

	// Wait for every outstanding frame, then let the pipeline drain.
	task automatic settle();
		do @(negedge clk); while (frames_due_cnt != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic add_record(input int which, input logic [31:0] size, input int body);
		logic [31:0] m;
		m = MAGIC[which];
		for (int i = 3; i >= 0; i--)
			file_bytes.push_back(m[i*8 +: 8]);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(size[i*8 +: 8]);
		repeat (body) file_bytes.push_back(8'($urandom));
	endtask

	// File ends trim bytes short of what is sent, so the tail is dropped.
	task automatic play(input int trim);
		file_len = file_pos + file_bytes.size() - trim;
		write_reg(CFG_FILE_LENGTH, file_len);
		stream_file();
		settle();
	endtask

	task automatic add_random_chunk();
		logic [31:0] sz;
		int          top_sz;
		int          pick;
		int          at;
		top_sz = (hi_size < lo_size + 12) ? hi_size : lo_size + 12;
		if (top_sz < lo_size)
			top_sz = lo_size;
		pick = $urandom_range(0, 9);
		if (pick <= 5) begin
			sz = $urandom_range(lo_size, top_sz);
			add_record($urandom_range(0, 2), sz, sz);
		end else if (pick == 6) begin
			add_record($urandom_range(0, 2), 32'd0, 0);
		end else if (pick == 7) begin
			sz = top_sz + $urandom_range(1, 3);
			add_record($urandom_range(0, 2), sz, (sz > 20) ? 20 : sz);
		end else if (pick == 8) begin
			add_record($urandom_range(0, 2), $urandom, $urandom_range(0, 3));
		end else if ($urandom_range(0, 1) == 0) begin
			repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom));
		end else begin
			// header with one magic bit flipped
			add_record($urandom_range(0, 2), lo_size + 1, 0);
			at = file_bytes.size() - 8 + $urandom_range(0, 3);
			file_bytes[at] = file_bytes[at] ^ (8'd1 << $urandom_range(0, 7));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'd0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_FILE_LENGTH;
		cfg_data = 32'd0;
		hold_req = 1'b0;
		file_pos = 32'd0;
		file_len = FILE_LENGTH_RST;
		burst_left = 0;
		n_items = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// file length is still zero after reset: dropped
		file_bytes.push_back(8'h24);
		file_bytes.push_back(8'he9);
		stream_file();
		settle();

		// widest size window; zero size must still be refused
		write_reg(CFG_MIN_FRAME, 32'd0);
		write_reg(CFG_MAX_FRAME, 32'h00ff_ffff);
		add_record(0, 32'd1, 1);
		add_record(1, 32'd0, 0);
		play(0);

		// max of one via an oversized write; last frame ends on the file boundary
		write_reg(CFG_MAX_FRAME, 32'ha500_0001);
		write_reg(CFG_MIN_FRAME, 32'd1);
		write_reg(CFG_SPARE, 32'hffff_ffff);
		add_record(2, 32'd2, 0);
		add_record(0, 32'd1, 1);
		repeat (3) file_bytes.push_back(8'h24);
		play(3);

		// top of every range
		write_reg(CFG_MIN_FRAME, 32'h00ff_ffff);
		write_reg(CFG_MAX_FRAME, 32'h00ff_ffff);
		file_len = 32'hffff_ffff;
		write_reg(CFG_FILE_LENGTH, file_len);
		add_record(1, 32'h00ff_fffe, 0);
		add_record(2, 32'h0100_0000, 0);
		stream_file();
		settle();

		phase = 0;
		while (n_items < ITEM_TARGET) begin
			lo_size = ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom_range(1, 4));
			hi_size = ($urandom_range(0, 5) == 0) ? 24'hff_ffff
				: lo_size + 24'($urandom_range(0, 10));
			if (hi_size == 0)
				hi_size = 24'd1;
			write_reg(CFG_MIN_FRAME, 32'(lo_size));
			write_reg(CFG_MAX_FRAME, 32'(hi_size));
			// receiver holds off while this file streams in
			if (phase == 1)
				hold_req = 1'b1;
			chunk_target = $urandom_range(30, 80);
			while (file_bytes.size() < chunk_target)
				add_random_chunk();
			play(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			phase++;
		end

		settle();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("frame_header_resync_scanner: match");
		else
			$display("frame_header_resync_scanner: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/frh_pkg.sv
hdl/frh_cfg.sv
hdl/frh_scan.sv
hdl/frame_header_resync_scanner.sv
hdl/frh_chk.sv
verif/frh_frame_monitor.sv
verif/tb_frame_header_resync_scanner.sv
